// ===== design/dram_row_buffer_timing_macros.svh =====
// ----------------------------------------------------------------------------
// DRAM row buffer timing assertion macros
// Shared concurrent assertion forms for the row buffer timing checkers.
// ----------------------------------------------------------------------------
`ifndef DRAM_ROW_BUFFER_TIMING_MACROS_SVH
`define DRAM_ROW_BUFFER_TIMING_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DRBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define DRBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/drbt_pkg.sv =====
// ----------------------------------------------------------------------------
// DRAM row buffer timing package
// Types, register map, reset values and helpers shared by the block.
// ----------------------------------------------------------------------------
package drbt_pkg;

  localparam int CNT_W     = 48;
  localparam int LAT_W     = 12;
  localparam int TIME_W    = 10;
  localparam int SHIFT_W   = 4;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [LAT_W-1:0] FIXED_LATENCY = 12'd100;
  localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    OC_HIT      = 3'd0,
    OC_CONFLICT = 3'd1,
    OC_EMPTY    = 3'd2,
    OC_CLOSED   = 3'd3,
    OC_FIXED    = 3'd4
  } outcome_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TIMING_MODE = 3'd0,
    REG_PAGE_POLICY = 3'd1,
    REG_BUS_LAT     = 3'd2,
    REG_CAS_LAT     = 3'd3,
    REG_RAS_LAT     = 3'd4,
    REG_PRE_LAT     = 3'd5,
    REG_ROW_LINES   = 3'd6
  } reg_idx_t;

  localparam logic              RST_TIMING_MODE = 1'b1;
  localparam logic              RST_PAGE_POLICY = 1'b0;
  localparam logic [TIME_W-1:0] RST_BUS_LAT     = 10'd10;
  localparam logic [TIME_W-1:0] RST_CAS_LAT     = 10'd45;
  localparam logic [TIME_W-1:0] RST_RAS_LAT     = 10'd45;
  localparam logic [TIME_W-1:0] RST_PRE_LAT     = 10'd45;
  localparam logic [SHIFT_W-1:0] RST_ROW_LINES  = 4'd4;

  typedef struct packed {
    logic               timing_mode;
    logic               page_policy;
    logic [TIME_W-1:0]  bus_latency;
    logic [TIME_W-1:0]  cas_latency;
    logic [TIME_W-1:0]  ras_latency;
    logic [TIME_W-1:0]  precharge_latency;
    logic [SHIFT_W-1:0] row_lines_log2;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic eval;
    logic accum;
  } ctrl_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_EVAL   = 4'b0100,
    S_ACCUM  = 4'b1000
  } state_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

// ===== design/drbt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module drbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/drbt_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the timing mode, policy and latencies.
// ----------------------------------------------------------------------------
module drbt_cfg
  import drbt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[REG_IDX_W+1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timing_mode       <= RST_TIMING_MODE;
      cfg.page_policy       <= RST_PAGE_POLICY;
      cfg.bus_latency       <= RST_BUS_LAT;
      cfg.cas_latency       <= RST_CAS_LAT;
      cfg.ras_latency       <= RST_RAS_LAT;
      cfg.precharge_latency <= RST_PRE_LAT;
      cfg.row_lines_log2    <= RST_ROW_LINES;
    end else if (wr_en) begin
      unique case (idx)
        REG_TIMING_MODE: cfg.timing_mode       <= pwdata[0];
        REG_PAGE_POLICY: cfg.page_policy       <= pwdata[0];
        REG_BUS_LAT:     cfg.bus_latency       <= pwdata[TIME_W-1:0];
        REG_CAS_LAT:     cfg.cas_latency       <= pwdata[TIME_W-1:0];
        REG_RAS_LAT:     cfg.ras_latency       <= pwdata[TIME_W-1:0];
        REG_PRE_LAT:     cfg.precharge_latency <= pwdata[TIME_W-1:0];
        REG_ROW_LINES:   cfg.row_lines_log2    <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TIMING_MODE: prdata = PDATA_W'(cfg.timing_mode);
      REG_PAGE_POLICY: prdata = PDATA_W'(cfg.page_policy);
      REG_BUS_LAT:     prdata = PDATA_W'(cfg.bus_latency);
      REG_CAS_LAT:     prdata = PDATA_W'(cfg.cas_latency);
      REG_RAS_LAT:     prdata = PDATA_W'(cfg.ras_latency);
      REG_PRE_LAT:     prdata = PDATA_W'(cfg.precharge_latency);
      REG_ROW_LINES:   prdata = PDATA_W'(cfg.row_lines_log2);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== design/drbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Access controller
// Sequences each access through lookup, evaluate and accumulate steps.
// ----------------------------------------------------------------------------
module drbt_ctrl
  import drbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  // The accumulate step only touches the counters, so a new transaction may
  // enter while it runs.
  assign busy   = (state == S_LOOKUP) || (state == S_EVAL);
  assign accept = start && !busy;

  always_comb begin
    unique case (state)
      S_IDLE:   state_next = accept ? S_LOOKUP : S_IDLE;
      S_LOOKUP: state_next = S_EVAL;
      S_EVAL:   state_next = S_ACCUM;
      S_ACCUM:  state_next = accept ? S_LOOKUP : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_ACCUM);
    end
  end

  assign cmd.capture = accept;
  assign cmd.lookup  = (state == S_LOOKUP);
  assign cmd.eval    = (state == S_EVAL);
  assign cmd.accum   = (state == S_ACCUM);

endmodule

// ===== design/drbt_datapath.sv =====
// ----------------------------------------------------------------------------
// Row buffer datapath
// Bank state, row compare, latency selection and saturating statistics.
// ----------------------------------------------------------------------------
module drbt_datapath
  import drbt_pkg::*;
#(
  parameter int BANKS     = 16,
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_cmd_t            cmd,
  input  cfg_t                 cfg,
  input  logic [ADDR_BITS-1:0] line_addr,
  input  logic                 is_write,
  output logic [LAT_W-1:0]     latency,
  output logic [2:0]           outcome,
  output logic [CNT_W-1:0]     read_count,
  output logic [CNT_W-1:0]     write_count,
  output logic [CNT_W-1:0]     read_latency_total,
  output logic [CNT_W-1:0]     write_latency_total,
  output logic [CNT_W-1:0]     miss_count
);

  localparam int BANK_W = $clog2(BANKS);
  localparam int ROW_W  = ADDR_BITS - BANK_W;

  logic [ADDR_BITS-1:0] addr_q;
  logic                 wr_q;
  logic [ROW_W-1:0]     row_q;
  logic [ROW_W-1:0]     row_rd;
  logic [BANK_W-1:0]    bank;
  logic [BANKS-1:0]     bank_open;
  logic [LAT_W-1:0]     lat_q;
  outcome_t             oc_q;
  logic                 miss_q;

  logic [LAT_W-1:0]     lat_c;
  outcome_t             oc_c;
  logic                 miss_c;
  logic                 row_wr_c;

  assign bank = addr_q[BANK_W-1:0];

  drbt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BANKS)
  ) u_row_ram (
    .clk   (clk),
    .we    (cmd.eval && row_wr_c),
    .waddr (bank),
    .wdata (row_q),
    .re    (cmd.lookup),
    .raddr (bank),
    .rdata (row_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_q <= line_addr;
      wr_q   <= is_write;
    end
    if (cmd.lookup) begin
      row_q <= ROW_W'(addr_q >> BANK_W) >> cfg.row_lines_log2;
    end
    if (cmd.eval) begin
      lat_q  <= lat_c;
      oc_q   <= oc_c;
      miss_q <= miss_c;
    end
  end

  always_comb begin
    lat_c    = FIXED_LATENCY;
    oc_c     = OC_FIXED;
    miss_c   = 1'b0;
    row_wr_c = 1'b0;
    if (!cfg.timing_mode) begin
      lat_c = FIXED_LATENCY;
      oc_c  = OC_FIXED;
    end else if (cfg.page_policy) begin
      lat_c  = LAT_W'(cfg.bus_latency) + LAT_W'(cfg.cas_latency)
             + LAT_W'(cfg.ras_latency);
      oc_c   = OC_CLOSED;
      miss_c = 1'b1;
    end else if (bank_open[bank] && (row_rd == row_q)) begin
      lat_c = LAT_W'(cfg.bus_latency) + LAT_W'(cfg.cas_latency);
      oc_c  = OC_HIT;
    end else if (bank_open[bank]) begin
      lat_c    = LAT_W'(cfg.bus_latency) + LAT_W'(cfg.precharge_latency)
               + LAT_W'(cfg.ras_latency) + LAT_W'(cfg.cas_latency);
      oc_c     = OC_CONFLICT;
      miss_c   = 1'b1;
      row_wr_c = 1'b1;
    end else begin
      lat_c    = LAT_W'(cfg.bus_latency) + LAT_W'(cfg.ras_latency)
               + LAT_W'(cfg.cas_latency);
      oc_c     = OC_EMPTY;
      miss_c   = 1'b1;
      row_wr_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_open           <= '0;
      read_count          <= '0;
      write_count         <= '0;
      read_latency_total  <= '0;
      write_latency_total <= '0;
      miss_count          <= '0;
    end else begin
      if (cmd.eval && row_wr_c) begin
        bank_open[bank] <= 1'b1;
      end
      if (cmd.accum) begin
        if (wr_q) begin
          write_count         <= sat_add(write_count, CNT_W'(1));
          write_latency_total <= sat_add(write_latency_total, CNT_W'(lat_q));
        end else begin
          read_count         <= sat_add(read_count, CNT_W'(1));
          read_latency_total <= sat_add(read_latency_total, CNT_W'(lat_q));
        end
        if (miss_q) begin
          miss_count <= sat_add(miss_count, CNT_W'(1));
        end
      end
    end
  end

  assign latency = lat_q;
  assign outcome = oc_q;

endmodule

// ===== design/dram_row_buffer_timing.sv =====
// A result strobes on done, registered after the accumulate step that follows lookup
// and evaluate; a new transaction may be accepted during the accumulate step of the last
// one, while lookup and evaluate sit around the registered read of the bank row RAM.
// Reset clears the bank valid bits, all statistics counters and the controller,
// and returns the configuration registers to their defaults; the receiver cannot stall.
// ----------------------------------------------------------------------------
// DRAM row buffer timing
// Charges fixed, open or closed page DRAM latency per line access and keeps stats.
// ----------------------------------------------------------------------------
module dram_row_buffer_timing
  import drbt_pkg::*;
#(
  parameter int BANKS     = 16,
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_BITS-1:0] line_addr,
  input  logic                 is_write,
  output logic                 done,
  output logic [LAT_W-1:0]     latency,
  output logic [2:0]           outcome,
  output logic [CNT_W-1:0]     read_count,
  output logic [CNT_W-1:0]     write_count,
  output logic [CNT_W-1:0]     read_latency_total,
  output logic [CNT_W-1:0]     write_latency_total,
  output logic [CNT_W-1:0]     miss_count,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;

  drbt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drbt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  drbt_datapath #(
    .BANKS     (BANKS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .cfg                 (cfg),
    .line_addr           (line_addr),
    .is_write            (is_write),
    .latency             (latency),
    .outcome             (outcome),
    .read_count          (read_count),
    .write_count         (write_count),
    .read_latency_total  (read_latency_total),
    .write_latency_total (write_latency_total),
    .miss_count          (miss_count)
  );

endmodule

// ===== design/drbt_checker.sv =====
// ----------------------------------------------------------------------------
// DRAM row buffer timing checker
// Port-level assertions on sequencing and result codes, bound to the top.
// ----------------------------------------------------------------------------
`include "dram_row_buffer_timing_macros.svh"

module drbt_checker
  import drbt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [LAT_W-1:0] latency,
  input logic [2:0]       outcome
);

  // Accepted transactions pass lookup and evaluate between accumulate steps, so strobes never touch.
  `DRBT_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")

  `DRBT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")

  `DRBT_ASSERT_NOW(a_outcome_code, done, (outcome == OC_HIT) || (outcome == OC_CONFLICT) || (outcome == OC_EMPTY) || (outcome == OC_CLOSED) || (outcome == OC_FIXED), "undefined outcome code")

  `DRBT_ASSERT_NOW(a_fixed_latency, done && (outcome == OC_FIXED), latency == FIXED_LATENCY, "fixed mode latency is not the fixed value")

endmodule

bind dram_row_buffer_timing drbt_checker u_drbt_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .latency (latency),
  .outcome (outcome)
);
